// ----- hw/rtl/bpms_pkg.sv -----
package bpms_pkg;

    // Button count is fixed by the front panel
    localparam int NumButtons = 4;

    // Button roles
    localparam int BtnBlackout = 0;
    localparam int BtnPrev     = 1;
    localparam int BtnNext     = 2;
    localparam int BtnGo       = 3;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_MACRO_COUNT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PUSH   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [8:0]  RstMacroCount = 9'd16;
    localparam logic [15:0] RstDebounce   = 16'd50;
    localparam logic [15:0] RstLongPush   = 16'd1000;

    // Remote control mode
    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_LOCKED = 2'd2
    } t_mode;

    // Push events of one tick, one bit per button
    typedef struct packed {
        logic [NumButtons-1:0] shorts;
        logic [NumButtons-1:0] longs;
    } t_push_evt;

    // Controller state as seen after one item
    typedef struct packed {
        t_mode      mode;
        logic [7:0] active;
        logic [7:0] preview;
        logic       lamp;
    } t_ctrl_state;

endpackage

// ----- hw/rtl/bpms_lane.sv -----
module bpms_lane import bpms_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick,        // a sample item (not a force item) is accepted this cycle
    input  logic        i_raw,         // button level, 0 pressed
    input  logic [15:0] i_debounce,
    input  logic [15:0] i_long_push,
    output logic        o_short,
    output logic        o_long
);

    localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  r_level;
    logic                  r_armed;
    logic [TIMER_BITS-1:0] r_timer;
    logic                  n_level;
    logic                  n_armed;
    logic [TIMER_BITS-1:0] n_timer;
    logic [TIMER_BITS-1:0] w_elapsed;
    logic                  w_over_db;
    logic                  w_over_long;

    // Saturating held-tick count
    assign w_elapsed   = (r_timer == '1) ? r_timer : r_timer + 1'b1;
    assign w_over_db   = CmpW'(w_elapsed) > CmpW'(i_debounce);
    assign w_over_long = CmpW'(w_elapsed) > CmpW'(i_long_push);

    // Press / release classification
    always_comb begin
        n_level = r_level;
        n_armed = r_armed;
        n_timer = r_timer;
        o_short = 1'b0;
        o_long  = 1'b0;
        if (i_tick) begin
            if (!i_raw) begin
                if (r_level) begin
                    // press edge: restart and arm
                    n_level = 1'b0;
                    n_timer = '0;
                    n_armed = 1'b1;
                end else begin
                    n_timer = w_elapsed;
                    if (r_armed && w_over_long) begin
                        o_long  = 1'b1;
                        n_armed = 1'b0;
                    end
                end
            end else if (!r_level) begin
                // release edge
                n_level = 1'b1;
                n_timer = w_elapsed;
                o_short = r_armed && w_over_db;
                n_armed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_armed <= 1'b0;
            r_timer <= '0;
        end else begin
            r_level <= n_level;
            r_armed <= n_armed;
            r_timer <= n_timer;
        end
    end

endmodule

// ----- hw/rtl/bpms_ctrl.sv -----
module bpms_ctrl import bpms_pkg::*; #(
    parameter int MAX_MACROS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,        // item accepted this cycle
    input  logic        i_force,       // item forces automatic mode
    input  t_push_evt   i_evt,
    input  logic [8:0]  i_macro_count,
    output t_ctrl_state o_state        // state after this item
);

    localparam logic [8:0] MaxCnt = 9'(MAX_MACROS);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic [8:0]  w_cnt;
    logic [7:0]  w_last;

    // Effective macro count, clamped to 1..MAX_MACROS
    always_comb begin
        w_cnt = i_macro_count;
        if (w_cnt == 9'd0) w_cnt = 9'd1;
        if (w_cnt > MaxCnt) w_cnt = MaxCnt;
    end
    assign w_last = 8'(w_cnt - 9'd1);

    // Merge the lane events in button order
    always_comb begin
        n_state = r_state;
        if (i_force) begin
            n_state.mode = MODE_AUTO;
        end else begin
            for (int i = 0; i < NumButtons; i++) begin
                if (i_evt.shorts[i]) begin
                    case (i)
                        BtnBlackout: begin
                            n_state.active = 8'd0;
                            if (n_state.mode == MODE_AUTO) n_state.mode = MODE_MANUAL;
                        end
                        BtnPrev: begin
                            n_state.preview = (n_state.preview == 8'd0) ? w_last
                                                                       : n_state.preview - 8'd1;
                        end
                        BtnNext: begin
                            n_state.preview = ({1'b0, n_state.preview} + 9'd1 >= w_cnt)
                                              ? 8'd0 : n_state.preview + 8'd1;
                        end
                        default: begin
                            n_state.active = n_state.preview;
                            if (n_state.mode == MODE_AUTO) n_state.mode = MODE_MANUAL;
                        end
                    endcase
                end else if (i_evt.longs[i]) begin
                    case (i)
                        BtnBlackout: begin
                            n_state.active = 8'd0;
                            n_state.mode   = (n_state.mode == MODE_LOCKED) ? MODE_MANUAL
                                                                           : MODE_LOCKED;
                        end
                        BtnPrev, BtnNext: begin
                            n_state.lamp = ~n_state.lamp;
                        end
                        default: begin
                            n_state.active = n_state.preview;
                            n_state.mode   = (n_state.mode == MODE_LOCKED) ? MODE_MANUAL
                                                                           : MODE_LOCKED;
                        end
                    endcase
                end
            end
        end
    end

    assign o_state = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= MODE_AUTO;
            r_state.active  <= 8'd0;
            r_state.preview <= 8'd0;
            r_state.lamp    <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/button_push_macro_selector.sv -----
// Each result is registered in the output register, or in the skid entry while m_axis
// stalls. Throughput: one item per cycle while the skid entry is empty; four button
// lanes and the merge stage update all state in the accept cycle, and a two-entry
// output buffer keeps s_axis open while one result waits. Reset (i_rst_n low, synchronous)
// restores the register defaults and treats all buttons as pressed and unarmed.
module button_push_macro_selector import bpms_pkg::*; #(
    parameter int MAX_MACROS = 256,
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [3:0] buttons_raw
    input  logic                 s_axis_tuser,   // [0] mode
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [1:0] remote_mode, [9:2] active_macro,
                                                 // [17:10] preview_macro, [18] lamp_on,
                                                 // [22:19] short_pushes, [26:23] long_pushes
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [8:0]  r_cnt;
    logic [15:0] r_debounce;
    logic [15:0] r_long_push;

    logic        w_in_fire;
    logic        w_out_fire;
    logic        w_tick;
    t_push_evt   w_evt;
    t_ctrl_state w_state;
    logic [31:0] w_result;

    logic        r_o_valid;
    logic [31:0] r_o_data;
    logic        r_sk_valid;
    logic [31:0] r_sk_data;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= RstMacroCount;
            r_debounce    <= RstDebounce;
            r_long_push   <= RstLongPush;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MACRO_COUNT: r_cnt       <= i_cfg_data[8:0];
                    CFG_DEBOUNCE:    r_debounce  <= i_cfg_data;
                    CFG_LONG_PUSH:   r_long_push <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Handshakes
    assign s_axis_tready = !r_sk_valid;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = r_o_valid && m_axis_tready;
    assign w_tick        = w_in_fire && !s_axis_tuser;

    // Button lanes
    for (genvar g = 0; g < NumButtons; g++) begin : g_lane
        bpms_lane #(
            .TIMER_BITS (TIMER_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (w_tick),
            .i_raw       (s_axis_tdata[g]),
            .i_debounce  (r_debounce),
            .i_long_push (r_long_push),
            .o_short     (w_evt.shorts[g]),
            .o_long      (w_evt.longs[g])
        );
    end

    // Merge stage and macro controller
    bpms_ctrl #(
        .MAX_MACROS (MAX_MACROS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_in_fire),
        .i_force       (s_axis_tuser),
        .i_evt         (w_evt),
        .i_macro_count (r_cnt),
        .o_state       (w_state)
    );

    assign w_result = {5'd0, w_evt.longs, w_evt.shorts, w_state.lamp,
                       w_state.preview, w_state.active, 2'(w_state.mode)};

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            if (w_out_fire || !r_o_valid) begin
                r_o_valid  <= r_sk_valid || w_in_fire;
                r_sk_valid <= 1'b0;
            end else if (w_in_fire) begin
                r_sk_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_o_valid) begin
            r_o_data <= r_sk_valid ? r_sk_data : w_result;
        end else if (w_in_fire) begin
            r_sk_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

`ifndef SYNTHESIS
    // a button never gives a short and a long push in the same tick
    a_no_dual_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_evt.shorts & w_evt.longs) == '0)
        else $error("short and long push on one button");

    // a force item gives no push events
    a_force_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && s_axis_tuser) |-> ((w_evt.shorts | w_evt.longs) == '0))
        else $error("push event on force item");

    // the skid entry is only used behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid valid with empty output");

    // an item accepted while the output stalls lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_o_valid && !m_axis_tready) |=> r_sk_valid)
        else $error("stalled item lost");

    // remote mode never takes the unused code
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("bad remote mode");
`endif

endmodule
